@@ hdl/skvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
    } ctrl_t;

endpackage

`default_nettype wire

@@ hdl/skvt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skvt_ctrl
    import skvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    output logic       result_valid,
    output ctrl_t      ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == S_UPD);
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign ctrl.capture = (state_reg == S_IDLE) && start;
    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.update  = (state_reg == S_UPD);

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> (state_reg == S_CMP))
        else $error("accepted word did not advance to compare");

    a_update_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |=> result_valid && !busy)
        else $error("update did not produce a result strobe");

    a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

endmodule

`default_nettype wire

@@ hdl/skvt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skvt_datapath
    import skvt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctrl_t               ctrl,
    input  wire logic [1:0]          cmd,
    input  wire logic signed [31:0]  key,
    input  wire logic signed [31:0]  new_value,
    input  wire logic [POS_W-1:0]    erase_position,
    output logic signed [31:0]       read_value,
    output logic                     was_present,
    output logic [POS_W-1:0]         entry_position,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count
);

    // Table cells and captured word
    word_t             keys_reg [CAPACITY];
    word_t             vals_reg [CAPACITY];
    word_t             keys_next [CAPACITY];
    word_t             vals_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    cmd_t              cmd_reg;
    word_t             key_reg;
    word_t             nv_reg;
    logic [POS_W-1:0]  epos_reg;

    // Compare results
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] eq_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic                present_reg;

    // Result
    word_t             value_next;
    logic              present_next;
    logic [POS_W-1:0]  position_next;
    status_t           status_next;
    logic [POS_W-1:0]  rd_idx;
    word_t             rd_val;
    logic              insert_ok;

    word_t             value_reg;
    logic              present_out_reg;
    logic [POS_W-1:0]  position_reg;
    status_t           status_reg;

    // Parallel compare of every occupied cell against the key
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_vec[i] = (CNT_W'(i) < count_reg) && (keys_reg[i] < key_reg);
            eq_vec[i] = (CNT_W'(i) < count_reg) && (keys_reg[i] == key_reg);
        end
    end

    assign rd_idx = (cmd_reg == CMD_ERASE) ? epos_reg : pos_reg[POS_W-1:0];
    assign rd_val = vals_reg[rd_idx];

    always_comb
    begin
        keys_next     = keys_reg;
        vals_next     = vals_reg;
        count_next    = count_reg;
        value_next    = '0;
        present_next  = 1'b0;
        position_next = '0;
        status_next   = ST_OK;
        insert_ok     = 1'b0;
        unique case (cmd_reg)
            CMD_ERASE:
            begin
                position_next = epos_reg;
                if ({1'b0, epos_reg} >= count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    // Close the gap: every cell from the position up to the second-highest takes its upper neighbor
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (CNT_W'(i) >= {1'b0, epos_reg})
                        begin
                            keys_next[i] = keys_reg[i+1];
                            vals_next[i] = vals_reg[i+1];
                        end
                    end
                    count_next   = count_reg - CNT_W'(1);
                    value_next   = rd_val;
                    present_next = 1'b1;
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                if (present_reg)
                begin
                    position_next = pos_reg[POS_W-1:0];
                    present_next  = 1'b1;
                    if (cmd_reg == CMD_WRITE)
                    begin
                        vals_next[pos_reg[POS_W-1:0]] = nv_reg;
                        value_next = nv_reg;
                    end
                    else
                    begin
                        value_next = rd_val;
                    end
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // Open a slot: cells above the insert position take their lower neighbor
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (CNT_W'(i) > pos_reg)
                        begin
                            keys_next[i] = keys_reg[i-1];
                            vals_next[i] = vals_reg[i-1];
                        end
                    end
                    keys_next[pos_reg[POS_W-1:0]] = key_reg;
                    vals_next[pos_reg[POS_W-1:0]] = (cmd_reg == CMD_WRITE) ? nv_reg : '0;
                    value_next    = (cmd_reg == CMD_WRITE) ? nv_reg : '0;
                    position_next = pos_reg[POS_W-1:0];
                    count_next    = count_reg + CNT_W'(1);
                    insert_ok     = 1'b1;
                end
            end
            CMD_NOP:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.update)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= cmd_t'(cmd);
            key_reg  <= key;
            nv_reg   <= new_value;
            epos_reg <= erase_position;
        end
        if (ctrl.compare)
        begin
            eq_reg      <= eq_vec;
            pos_reg     <= CNT_W'($countones(lt_vec));
            present_reg <= |eq_vec;
        end
        if (ctrl.update)
        begin
            keys_reg        <= keys_next;
            vals_reg        <= vals_next;
            value_reg       <= value_next;
            present_out_reg <= present_next;
            position_reg    <= position_next;
            status_reg      <= status_next;
        end
    end

    assign read_value     = value_reg;
    assign was_present    = present_out_reg;
    assign entry_position = position_reg;
    assign status         = status_reg;
    assign entry_count    = count_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> $onehot0(eq_reg))
        else $error("key matched more than one cell");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.update && status_next == ST_FULL) |=> $stable(count_reg))
        else $error("full table changed its count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.update && insert_ok) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

endmodule

`default_nettype wire

@@ hdl/sorted_key_value_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table: up to 16 pairs of signed 32-bit key and value,
// held in register cells in ascending key order.
//
// Command channel: drive cmd, key, new_value and erase_position with start
// high; the word is taken on the edge where start is high and busy is low.
// A read or write looks the key up, inserting it at its sorted place when it
// is absent and the table is not full; an erase removes the entry at erase_position.
//
// Result channel: result_valid pulses for exactly one cycle with the result
// word on read_value, was_present, entry_position, status and entry_count.
// The receiver cannot hold results off; capture them on the strobe.
//
// Timing: an accepted word passes through the compare state, where all
// cells are compared in parallel, then the update state, where cells are
// shifted/written and the result and strobe are registered. busy drops in
// the strobe cycle, so a new word is taken at the earliest as it ends.
//
// Reset (rst_n low, asynchronous) empties the table; cell contents are not
// cleared, only entries below the count are ever looked at.

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          cmd,
    input  wire logic signed [31:0]  key,
    input  wire logic signed [31:0]  new_value,
    input  wire logic [POS_W-1:0]    erase_position,
    output logic                     result_valid,
    output logic signed [31:0]       read_value,
    output logic                     was_present,
    output logic [POS_W-1:0]         entry_position,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count
);

    ctrl_t ctrl;

    // Sequence each word through capture, compare and update
    skvt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .ctrl         (ctrl)
    );

    // Hold the cells, compare keys, shift and form the result word
    skvt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cmd            (cmd),
        .key            (key),
        .new_value      (new_value),
        .erase_position (erase_position),
        .read_value     (read_value),
        .was_present    (was_present),
        .entry_position (entry_position),
        .status         (status),
        .entry_count    (entry_count)
    );

endmodule

`default_nettype wire

@@ bench/tb_sorted_key_value_table.sv @@
`timescale 1ns / 1ps

module tb_sorted_key_value_table;
    import skvt_pkg::*;

    // One result word as the block reports it.
    typedef struct packed {
        word_t              value;
        logic               present;
        logic [POS_W-1:0]   pos;
        status_t            st;
        logic [CNT_W-1:0]   count;
    } table_result_t;

    localparam int MAX_REPORTS = 10;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          cmd;
    logic signed [31:0]  key;
    logic signed [31:0]  new_value;
    logic [POS_W-1:0]    erase_position;
    logic                result_valid;
    logic signed [31:0]  read_value;
    logic                was_present;
    logic [POS_W-1:0]    entry_position;
    logic [1:0]          status;
    logic [CNT_W-1:0]    entry_count;

    // Shadow copy of the table, advanced once per accepted command word.
    word_t table_keys [CAPACITY];
    word_t table_vals [CAPACITY];
    int    table_count;

    // Results owed by the block, oldest first.
    table_result_t pending_results [$];

    int mismatch_count;
    int gapless_left;

    sorted_key_value_table uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .key            (key),
        .new_value      (new_value),
        .erase_position (erase_position),
        .result_valid   (result_valid),
        .read_value     (read_value),
        .was_present    (was_present),
        .entry_position (entry_position),
        .status         (status),
        .entry_count    (entry_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command word to the shadow table and return the result the
    // block owes for it. The insert slot is the first entry whose key is not
    // below the new key, which is where a binary search lands as well.
    function automatic table_result_t apply_table_word(cmd_t c, word_t k, word_t v,
                                                       logic [POS_W-1:0] p);
        table_result_t r;
        int            slot;
        int            i;
        bit            hit;

        r.value   = '0;
        r.present = 1'b0;
        r.pos     = '0;
        r.st      = ST_OK;
        case (c)
            CMD_ERASE:
            begin
                r.pos = p;
                if (p >= table_count)
                    r.st = ST_RANGE;
                else
                begin
                    r.value   = table_vals[p];
                    r.present = 1'b1;
                    // close the gap left by the removed entry
                    for (i = p; i < table_count - 1; i++)
                    begin
                        table_keys[i] = table_keys[i + 1];
                        table_vals[i] = table_vals[i + 1];
                    end
                    table_count--;
                end
            end
            CMD_READ, CMD_WRITE:
            begin
                slot = 0;
                hit  = 1'b0;
                while (slot < table_count && table_keys[slot] < k)
                    slot++;
                if (slot < table_count && table_keys[slot] == k)
                    hit = 1'b1;
                if (hit)
                begin
                    if (c == CMD_WRITE)
                        table_vals[slot] = v;
                    r.value   = table_vals[slot];
                    r.present = 1'b1;
                    r.pos     = slot[POS_W-1:0];
                end
                else if (table_count >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    // open a hole at the sorted slot, then fill it
                    for (i = table_count; i > slot; i--)
                    begin
                        table_keys[i] = table_keys[i - 1];
                        table_vals[i] = table_vals[i - 1];
                    end
                    table_keys[slot] = k;
                    table_vals[slot] = (c == CMD_WRITE) ? v : '0;
                    table_count++;
                    r.value = table_vals[slot];
                    r.pos   = slot[POS_W-1:0];
                end
            end
            default: ;
        endcase
        r.count = table_count[CNT_W-1:0];
        return r;
    endfunction

    // Send one command word. Hold off a random number of cycles first
    // (none during a gapless stretch), hold the word until the block takes
    // it, then record what the block owes. Return at the next falling edge
    // with start still high so a back-to-back word keeps the line up.
    task automatic send_word(cmd_t c, word_t k, word_t v, logic [POS_W-1:0] p);
        int gap;

        if (gapless_left > 0)
        begin
            gapless_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0)
                gapless_left = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd            = c;
        key            = k;
        new_value      = v;
        erase_position = p;
        start          = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.push_back(apply_table_word(c, k, v, p));
        @(negedge clk);
    endtask

    // Empty table: an erase has nothing to remove, the unused command does
    // nothing, and the first accesses insert the extreme keys.
    task automatic test_empty_table();
        send_word(CMD_ERASE, 32'sd0, 32'sd0, 4'd0);
        send_word(CMD_NOP, 32'sh7fff_ffff, 32'sh7fff_ffff, 4'd15);
        send_word(CMD_READ, 32'sh8000_0000, 32'sh5555_5555, 4'd0);
        send_word(CMD_WRITE, 32'sh7fff_ffff, 32'sh8000_0000, 4'd0);
    endtask

    // Hits on the extreme keys, a write over an existing entry, and an
    // insert that lands between them.
    task automatic test_table_extremes();
        send_word(CMD_WRITE, 32'sh8000_0000, 32'shffff_ffff, 4'd0);
        send_word(CMD_READ, 32'sh7fff_ffff, 32'sd0, 4'd15);
        send_word(CMD_WRITE, 32'sd0, 32'sh7fff_ffff, 4'd0);
        send_word(CMD_NOP, 32'sd0, 32'sd0, 4'd0);
    endtask

    // Fill every slot, then try to grow past capacity with both access
    // kinds, and check that hits still work while full.
    task automatic test_fill_to_capacity();
        int i;

        for (i = 0; table_count < CAPACITY; i++)
            send_word(CMD_WRITE, i * 1000003 - 6000000, $urandom, 4'd0);
        send_word(CMD_READ, 32'sd12345, 32'sd0, 4'd0);
        send_word(CMD_WRITE, -32'sd12345, 32'sh1234_5678, 4'd0);
        send_word(CMD_READ, 32'sh7fff_ffff, 32'sd0, 4'd0);
    endtask

    // Remove the last and first entries, then point past the end.
    task automatic test_erase_edges();
        send_word(CMD_ERASE, 32'sd0, 32'sd0, 4'd15);
        send_word(CMD_ERASE, 32'sd0, 32'sd0, 4'd0);
        send_word(CMD_ERASE, 32'sd0, 32'sd0, 4'd15);
    endtask

    // Random traffic in blocks that alternate between growing and shrinking
    // the table, so it runs both full and empty. Keys come mostly from a small
    // pool so that hits, inserts and duplicate writes all happen often.
    task automatic test_random_traffic(int n_words);
        word_t            key_pool [32];
        bit               shrink;
        int               i;
        int               j;
        int               pick;
        cmd_t             c;
        word_t            k;
        logic [POS_W-1:0] p;

        shrink = 1'b0;
        for (i = 0; i < n_words; i++)
        begin
            if (i % 50 == 0)
            begin
                shrink = (((i / 50) % 2) != 0);
                for (j = 0; j < 32; j++)
                    key_pool[j] = $urandom;
                key_pool[0] = 32'sh8000_0000;
                key_pool[1] = 32'sh7fff_ffff;
                key_pool[2] = 32'sd0;
                key_pool[3] = -32'sd1;
            end
            pick = $urandom_range(0, 99);
            if (pick < (shrink ? 75 : 10))
                c = CMD_ERASE;
            else if (pick < 97)
                c = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            else
                c = CMD_NOP;
            k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 31)];
            if (table_count > 0 && $urandom_range(0, 4) != 0)
                p = POS_W'($urandom_range(0, table_count - 1));
            else
                p = POS_W'($urandom_range(0, 15));
            send_word(c, k, $urandom, p);
        end
    endtask

    // Check each result word against the oldest expectation on its strobe.
    always @(posedge clk)
    begin : result_check
        table_result_t want;

        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%t: unexpected result value=%h present=%b pos=%0d st=%0d cnt=%0d",
                             $realtime, read_value, was_present, entry_position, status,
                             entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value || was_present !== want.present ||
                    entry_position !== want.pos || status !== want.st ||
                    entry_count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%t: mismatch expected value=%h present=%b pos=%0d st=%0d cnt=%0d",
                                 $realtime, want.value, want.present, want.pos, want.st,
                                 want.count);
                        $display("%t:          actual   value=%h present=%b pos=%0d st=%0d cnt=%0d",
                                 $realtime, read_value, was_present, entry_position, status,
                                 entry_count);
                    end
                end
            end
        end
    end

    initial
    begin
        int drain;

        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = CMD_READ;
        key            = '0;
        new_value      = '0;
        erase_position = '0;
        table_count    = 0;
        mismatch_count = 0;
        gapless_left   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_table_extremes();
        test_fill_to_capacity();
        test_erase_edges();
        test_random_traffic(600);
        start = 1'b0;

        // Drain: wait for every owed result, then a few more cycles to catch
        // any stray strobe.
        drain = 0;
        while (pending_results.size() > 0 && drain < 200)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_results.size() > 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatch_count += pending_results.size();
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/skvt_pkg.sv
hdl/skvt_ctrl.sv
hdl/skvt_datapath.sv
hdl/sorted_key_value_table.sv
bench/tb_sorted_key_value_table.sv
